### sv/euler_rotation_matrix_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix core
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_ROTATION_MATRIX_CORE_MACROS_SVH

`define ERM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ERM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Shared constants and helpers for the rotation matrix core.
// ----------------------------------------------------------------------------
`default_nettype none
package erm_pkg;
  localparam int CordicSteps = 30;
  localparam int PhaseBits   = 32;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sh026DD3B6A;

  function automatic logic signed [CordicW-1:0] atan_turn(input int i);
    logic signed [CordicW-1:0] t;
    case (i)
      0: t = 34'sh020000000;  1: t = 34'sh012E4051E;  2: t = 34'sh009FB385B;
      3: t = 34'sh0051111D4;  4: t = 34'sh0028B0D43;  5: t = 34'sh00145D7E1;
      6: t = 34'sh000A2F61E;  7: t = 34'sh000517C55;  8: t = 34'sh00028BE53;
      9: t = 34'sh000145F2F; 10: t = 34'sh0000A2F98; 11: t = 34'sh0000517CC;
      12: t = 34'sh000028BE6; 13: t = 34'sh0000145F3; 14: t = 34'sh00000A2FA;
      15: t = 34'sh00000517D; 16: t = 34'sh0000028BE; 17: t = 34'sh00000145F;
      18: t = 34'sh000000A30; 19: t = 34'sh000000518; 20: t = 34'sh00000028C;
      21: t = 34'sh000000146; 22: t = 34'sh0000000A3; 23: t = 34'sh000000051;
      24: t = 34'sh000000029; 25: t = 34'sh000000014; 26: t = 34'sh00000000A;
      27: t = 34'sh000000005; 28: t = 34'sh000000003; 29: t = 34'sh000000001;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

### sv/erm_cordic.sv
// ----------------------------------------------------------------------------
// erm_cordic
// Pipelined rotation CORDIC, one micro-rotation per stage, with an enable
// shared by the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module erm_cordic
  import erm_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  [ANGLE_BITS-1:0]      angle_i,
  output logic signed [FRAC_BITS+1:0] cos_o,
  output logic signed [FRAC_BITS+1:0] sin_o
);
  localparam int Sh = 30 - FRAC_BITS;
  localparam int OW = FRAC_BITS + 2;
  localparam logic signed [CordicW-1:0] Half = CordicW'((64'sd1 <<< Sh) >>> 1);

  logic signed [CordicW-1:0] x_q [CordicSteps+1];
  logic signed [CordicW-1:0] y_q [CordicSteps+1];
  logic signed [CordicW-1:0] z_q [CordicSteps+1];
  logic                      n_q [CordicSteps+1];
  logic signed [CordicW-1:0] z0, x_f, y_f, xr, yr;
  logic [PhaseBits-1:0]      ph;
  logic                      neg0;

  always_comb begin
    ph   = {angle_i, {(PhaseBits-ANGLE_BITS){1'b0}}};
    z0   = CordicW'($signed(ph));
    neg0 = 1'b0;
    if (z0 > (CordicW'(1) <<< 30)) begin
      z0 = z0 - (CordicW'(1) <<< 31); neg0 = 1'b1;
    end else if (z0 < -(CordicW'(1) <<< 30)) begin
      z0 = z0 + (CordicW'(1) <<< 31); neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= z0;
      n_q[0] <= neg0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (!z_q[i][CordicW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
      end
    end
  end

  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    r = (v + Half) >>> Sh;
    if (r > (CordicW'(1) <<< FRAC_BITS)) r = CordicW'(1) <<< FRAC_BITS;
    if (r < -(CordicW'(1) <<< FRAC_BITS)) r = -(CordicW'(1) <<< FRAC_BITS);
    return r[OW-1:0];
  endfunction

  always_comb begin
    x_f = n_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
    y_f = n_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];
    xr  = x_f;
    yr  = y_f;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= rnd_sat(xr);
      sin_o <= rnd_sat(yr);
    end
  end
endmodule
`default_nettype wire

### sv/erm_matrix.sv
// ----------------------------------------------------------------------------
// erm_matrix
// Product stages: partial products, then the nine rounded, saturated elements.
// ----------------------------------------------------------------------------
`default_nettype none
module erm_matrix
  import erm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  signed [FRAC_BITS+1:0] a_i, b_i, c_i, d_i, e_i, f_i,
  output logic        [15:0]          elem_o [9]
);
  localparam int W  = FRAC_BITS + 2;
  localparam int PW = 2 * W + 2;

  function automatic logic signed [PW-1:0] fmul(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
    logic signed [PW-1:0] p;
    p = PW'(x) * PW'(y);
    return (p + (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [15:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (r > (PW'(1) <<< FRAC_BITS)) r = PW'(1) <<< FRAC_BITS;
    if (r < -(PW'(1) <<< FRAC_BITS)) r = -(PW'(1) <<< FRAC_BITS);
    return r[15:0];
  endfunction

  logic signed [W-1:0] a1_q, b1_q, c1_q, d1_q, e1_q, f1_q, ad_q, bd_q;
  logic signed [PW-1:0] p_q [13];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a_i; b1_q <= b_i; c1_q <= c_i; d1_q <= d_i; e1_q <= e_i; f1_q <= f_i;
      ad_q <= W'(fmul(a_i, d_i));
      bd_q <= W'(fmul(b_i, d_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= fmul(c1_q, e1_q);
      p_q[1]  <= fmul(-c1_q, f1_q);
      p_q[2]  <= -PW'(d1_q);
      p_q[3]  <= fmul(-bd_q, e1_q);
      p_q[4]  <= fmul(a1_q, f1_q);
      p_q[5]  <= fmul(bd_q, f1_q);
      p_q[6]  <= fmul(a1_q, e1_q);
      p_q[7]  <= fmul(-b1_q, c1_q);
      p_q[8]  <= fmul(ad_q, e1_q);
      p_q[9]  <= fmul(b1_q, f1_q);
      p_q[10] <= fmul(-ad_q, f1_q);
      p_q[11] <= fmul(b1_q, e1_q);
      p_q[12] <= fmul(a1_q, c1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elem_o[0] <= sat(p_q[0]);
      elem_o[1] <= sat(p_q[1]);
      elem_o[2] <= sat(p_q[2]);
      elem_o[3] <= sat(p_q[3] + p_q[4]);
      elem_o[4] <= sat(p_q[5] + p_q[6]);
      elem_o[5] <= sat(p_q[7]);
      elem_o[6] <= sat(p_q[8] + p_q[9]);
      elem_o[7] <= sat(p_q[10] + p_q[11]);
      elem_o[8] <= sat(p_q[12]);
    end
  end
endmodule
`default_nettype wire

### sv/euler_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_rotation_matrix_core
// Rotation matrix from three binary angles.
//
// Input channel s_axis carries one angle triple per word; m_axis carries the
// nine Q1.14 matrix elements of that triple as one word. Three pipelined
// CORDIC units (one stage per micro-rotation) feed a three-stage product
// section. One word is taken every cycle while the receiver keeps up.
// The whole pipeline advances on one enable: when the output holds a word
// the receiver has not taken, every stage holds, and s_axis_tready drops
// only then. Nothing is lost or repeated under stall.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_rotation_matrix_core
  import erm_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [47:0]  s_axis_tdata,  // angle_x, angle_y, angle_z
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [143:0] m_axis_tdata   // elem_00 .. elem_22
);
  localparam int Lat = CordicSteps + 2 + 3;
  localparam int W   = FRAC_BITS + 2;

  logic                en;
  logic [Lat-1:0]      vld_q;
  logic signed [W-1:0] cs [3];
  logic signed [W-1:0] sn [3];
  logic [15:0]         elem [9];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cordic
    logic [ANGLE_BITS-1:0] ang;
    assign ang = ANGLE_BITS'(s_axis_tdata[16*k +: 16]);
    erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (ang),
      .cos_o   (cs[k]),
      .sin_o   (sn[k])
    );
  end

  erm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (cs[0]), .b_i (sn[0]),
    .c_i    (cs[1]), .d_i (sn[1]),
    .e_i    (cs[2]), .f_i (sn[2]),
    .elem_o (elem)
  );

  for (genvar j = 0; j < 9; j++) begin : g_out
    assign m_axis_tdata[16*j +: 16] = elem[j];
  end
endmodule
`default_nettype wire

### sv/euler_rotation_matrix_core_checker.sv
// ----------------------------------------------------------------------------
// euler_rotation_matrix_core_checker
// Port-level checks bound to the core.
// ----------------------------------------------------------------------------
`include "euler_rotation_matrix_core_macros.svh"
`default_nettype none
module euler_rotation_matrix_core_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [143:0] m_axis_tdata
);
  `ERM_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")
  `ERM_ASSERT(a_ready, clk_i, rst_ni, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready not tied to output drain")
  `ERM_ASSERT(a_e00, clk_i, rst_ni, m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16384 && $signed(m_axis_tdata[15:0]) >= -16384), "element out of range")
  `ERM_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid || !rst_ni, "valid after reset")
endmodule
bind euler_rotation_matrix_core euler_rotation_matrix_core_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### test/euler_rotation_matrix_checker.sv
// ----------------------------------------------------------------------------
// euler_rotation_matrix_checker
// Watches both stream channels of the rotation matrix core, predicts the nine
// Q1.14 elements of every accepted angle triple and compares them, in order,
// with the words leaving the core.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_checker (
  input  wire          clk_i,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [47:0]  s_axis_tdata,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [143:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o,
  output int           matrices_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import erm_pkg::*;

  localparam int FracBits = 14;
  localparam int IntFrac  = 30;
  localparam longint One  = 64'sd1 << FracBits;

  logic [143:0] matrix_q[$];

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > One) return One;
    if (v < -One) return -One;
    return v;
  endfunction

  function automatic longint round_half_up(longint v, int sh);
    if (sh == 0) return v;
    return sra(v + (64'sd1 << (sh - 1)), sh);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_half_up(a * b, FracBits);
  endfunction

  function automatic void cos_sin(input logic [15:0] ang, output longint c,
                                  output longint s);
    longint phase, x, y, xs, ys, t;
    bit flip;
    phase = longint'($signed({ang, 16'h0000}));
    flip = 1'b0;
    x = 64'sh26DD3B6A;
    y = 0;
    if (phase > (64'sd1 << 30)) begin
      phase -= 64'sd1 << 31;
      flip = 1'b1;
    end else if (phase < -(64'sd1 << 30)) begin
      phase += 64'sd1 << 31;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      t = longint'(atan_turn(i));
      if (phase >= 0) begin
        x -= ys; y += xs; phase -= t;
      end else begin
        x += ys; y -= xs; phase += t;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_one(round_half_up(x, IntFrac - FracBits));
    s = clamp_one(round_half_up(y, IntFrac - FracBits));
  endfunction

  function automatic logic [143:0] rotation_matrix(logic [47:0] angles);
    longint ca, sa, cb, sb, cc, sc, casb, sasb;
    longint e[9];
    logic [143:0] r;
    cos_sin(angles[15:0], ca, sa);
    cos_sin(angles[31:16], cb, sb);
    cos_sin(angles[47:32], cc, sc);
    casb = qmul(ca, sb);
    sasb = qmul(sa, sb);
    e[0] = qmul(cb, cc);
    e[1] = qmul(-cb, sc);
    e[2] = -sb;
    e[3] = qmul(-sasb, cc) + qmul(ca, sc);
    e[4] = qmul(sasb, sc) + qmul(ca, cc);
    e[5] = qmul(-sa, cb);
    e[6] = qmul(casb, cc) + qmul(sa, sc);
    e[7] = qmul(-casb, sc) + qmul(sa, cc);
    e[8] = qmul(ca, cb);
    for (int k = 0; k < 9; k++) r[k*16 +: 16] = 16'(clamp_one(e[k]));
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] error: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    matrices_seen_o = 0;
  end

  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    logic [143:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      matrices_seen_o++;
      if (matrix_q.size() == 0) begin
        report_mismatch("matrix word with no angle triple waiting");
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_axis_tdata[k*16 +: 16] !== want[k*16 +: 16])
            report_mismatch($sformatf("elem_%0d%0d got %h want %h", k / 3, k % 3,
                                      m_axis_tdata[k*16 +: 16], want[k*16 +: 16]));
      end
    end
    if (s_axis_tvalid && s_axis_tready) matrix_q.push_back(rotation_matrix(s_axis_tdata));
  end
endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives angle triples into the rotation matrix core, directed corners first
// and then random angles, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [143:0]  m_axis_tdata;
  int            fail_count, pending, matrices_seen;
  int            triples_sent = 0;
  bit            stim_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  euler_rotation_matrix_core u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  euler_rotation_matrix_checker u_checker (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .matrices_seen_o(matrices_seen)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_triple(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {az, ay, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    triples_sent++;
    @(negedge clk_i);
  endtask

  // receiver: stretches of full throughput alternate with random stalls
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(5, 40)) @(negedge clk_i);
      end
      g = gap_len();
      m_axis_tready <= (g == 0);
      repeat (g) @(negedge clk_i);
    end
  end

  initial begin
    logic [15:0] corners[10];
    corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                16'h4001, 16'h3FFF, 16'h7FFF, 16'hAAAA};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 10; i++)
      send_triple(corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10], 1'b0);
    send_triple(16'h5555, 16'hFFFF, 16'h0000, 1'b0);
    send_triple(16'h2000, 16'h2000, 16'h2000, 1'b0);
    s_axis_tvalid <= 1'b0;
    // hold until the pipeline has drained
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < 540; i++)
      send_triple(pick_angle(), pick_angle(), pick_angle(), i >= 100);
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("%0d angle triples sent, %0d matrices checked, corner angles included",
             triples_sent, matrices_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("euler_rotation_matrix_core: match");
    end else begin
      $display("euler_rotation_matrix_core: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("euler_rotation_matrix_core: mismatch");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/erm_pkg.sv
sv/erm_cordic.sv
sv/erm_matrix.sv
sv/euler_rotation_matrix_core.sv
sv/euler_rotation_matrix_core_checker.sv
test/euler_rotation_matrix_checker.sv
test/testbench.sv
